[rtl/core/pceth_pkg.sv]
package pceth_pkg;

    // Store geometry
    localparam int MAX_ELEMENTS = 384;
    localparam int ENERGY_BINS  = 4096;
    localparam int TIME_BINS    = 1024;

    localparam int E_DEPTH  = MAX_ELEMENTS * ENERGY_BINS;
    localparam int T_DEPTH  = MAX_ELEMENTS * TIME_BINS;
    localparam int EL_DEPTH = MAX_ELEMENTS;

    localparam int E_AW  = $clog2(E_DEPTH);
    localparam int T_AW  = $clog2(T_DEPTH);
    localparam int EL_AW = $clog2(EL_DEPTH);

    // Clearing sweep covers the deepest store
    localparam int CLR_DEPTH_ET = (E_DEPTH > T_DEPTH) ? E_DEPTH : T_DEPTH;
    localparam int CLR_DEPTH    = (CLR_DEPTH_ET > EL_DEPTH) ? CLR_DEPTH_ET : EL_DEPTH;
    localparam int CLR_W        = $clog2(CLR_DEPTH);

    // Field widths
    localparam int FUNC_W = 1;
    localparam int ELEM_W = 9;
    localparam int BIN_W  = 16;
    localparam int ACT_W  = 9;
    localparam int CNT_W  = 32;
    localparam int TOT_W  = 64;

    localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(192);

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_EVENT = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 1'b1;

    // Controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic capture;
        logic clr_step;
        logic rd;
        logic upd;
        logic reply;
    } pceth_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic [FUNC_W-1:0] item_func;
        logic              clr_last;
        logic              out_free;
    } pceth_sts_t;

endpackage

[rtl/core/pceth_in_if.sv]
interface pceth_in_if
    import pceth_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ELEM_W-1:0] element_index;
    logic [BIN_W-1:0]  energy_bin;
    logic [BIN_W-1:0]  time_bin;

    modport source (output valid, func, element_index, energy_bin, time_bin, input ready);
    modport sink   (input valid, func, element_index, energy_bin, time_bin, output ready);
endinterface

[rtl/core/pceth_out_if.sv]
interface pceth_out_if
    import pceth_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             accepted;
    logic [CNT_W-1:0] energy_count;
    logic [CNT_W-1:0] time_count;
    logic [TOT_W-1:0] element_total;
    logic [TOT_W-1:0] event_total;

    modport source (output valid, accepted, energy_count, time_count, element_total,
                    event_total, input ready);
    modport sink   (input valid, accepted, energy_count, time_count, element_total,
                    event_total, output ready);
endinterface

[rtl/core/pceth_cfg_if.sv]
interface pceth_cfg_if
    import pceth_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] active_elements;

    modport source (output valid, active_elements, input ready);
    modport sink   (input valid, active_elements, output ready);
endinterface

[rtl/core/pceth_ram.sv]
module pceth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/pceth_ctrl.sv]
module pceth_ctrl
    import pceth_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  pceth_sts_t st,
    output pceth_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_READ   = 5'b00100,
        S_UPDATE = 5'b01000,
        S_REPLY  = 5'b10000
    } pceth_state_t;

    pceth_state_t state_reg, state_next;
    logic         reply_reg, reply_next;   // sweep came from a clear transaction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            reply_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            reply_reg <= reply_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        reply_next = reply_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                begin
                    state_next = reply_reg ? S_REPLY : S_IDLE;
                    reply_next = 1'b0;
                end
            end
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (st.item_func == FUNC_CLEAR)
                    begin
                        state_next = S_CLEAR;
                        reply_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (st.out_free)
                begin
                    cmd.upd    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_REPLY:
            begin
                if (st.out_free)
                begin
                    cmd.reply  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_event_goes_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid && st.item_func == FUNC_EVENT)
        |=> state_reg == S_READ)
        else $error("event transaction did not start a read");

    a_update_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE && !st.out_free) |=> state_reg == S_UPDATE)
        else $error("update left while output register was full");

endmodule

[rtl/core/pceth_dp.sv]
module pceth_dp
    import pceth_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  pceth_cmd_t        cmd,
    output pceth_sts_t        st,
    // config
    input  logic              cfg_valid,
    input  logic [ACT_W-1:0]  cfg_data,
    // input payload
    input  logic [FUNC_W-1:0] func,
    input  logic [ELEM_W-1:0] element_index,
    input  logic [BIN_W-1:0]  energy_bin,
    input  logic [BIN_W-1:0]  time_bin,
    // result channel
    input  logic              out_ready,
    output logic              out_valid,
    output logic              out_accepted,
    output logic [CNT_W-1:0]  out_energy_count,
    output logic [CNT_W-1:0]  out_time_count,
    output logic [TOT_W-1:0]  out_element_total,
    output logic [TOT_W-1:0]  out_event_total
);

    localparam logic [ELEM_W:0]  MAX_ELEM_L  = (ELEM_W + 1)'(MAX_ELEMENTS);
    localparam logic [BIN_W:0]   E_BINS_L    = (BIN_W + 1)'(ENERGY_BINS);
    localparam logic [BIN_W:0]   T_BINS_L    = (BIN_W + 1)'(TIME_BINS);
    localparam logic [CLR_W:0]   E_DEPTH_L   = (CLR_W + 1)'(E_DEPTH);
    localparam logic [CLR_W:0]   T_DEPTH_L   = (CLR_W + 1)'(T_DEPTH);
    localparam logic [CLR_W:0]   EL_DEPTH_L  = (CLR_W + 1)'(EL_DEPTH);
    localparam logic [CLR_W-1:0] CLR_LAST    = CLR_W'(CLR_DEPTH - 1);

    logic [ACT_W-1:0] active_reg;
    logic             ok_reg, ok_next;
    logic [E_AW-1:0]  e_addr_reg, e_addr_next;
    logic [T_AW-1:0]  t_addr_reg, t_addr_next;
    logic [EL_AW-1:0] el_addr_reg;
    logic [TOT_W-1:0] glob_reg;
    logic [CLR_W-1:0] clr_cnt_reg;

    logic             out_valid_reg;
    logic             out_accepted_reg;
    logic [CNT_W-1:0] out_energy_reg, out_time_reg;
    logic [TOT_W-1:0] out_elem_reg, out_event_reg;

    logic             e_we, t_we, el_we, e_re, t_re, el_re;
    logic [E_AW-1:0]  e_waddr;
    logic [T_AW-1:0]  t_waddr;
    logic [EL_AW-1:0] el_waddr;
    logic [CNT_W-1:0] e_rdata, t_rdata, e_wdata, t_wdata, e_inc, t_inc;
    logic [TOT_W-1:0] el_rdata, el_wdata, el_inc, glob_inc;
    logic             clr_last, out_free;

    // Range check and bin addresses for the incoming event
    assign ok_next = ({1'b0, element_index} < {1'b0, active_reg})
                   && ({1'b0, element_index} < MAX_ELEM_L)
                   && ({1'b0, energy_bin} < E_BINS_L)
                   && ({1'b0, time_bin} < T_BINS_L);
    assign e_addr_next = E_AW'(32'(element_index) * 32'(ENERGY_BINS) + 32'(energy_bin));
    assign t_addr_next = T_AW'(32'(element_index) * 32'(TIME_BINS) + 32'(time_bin));

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ok_reg      <= ok_next;
            e_addr_reg  <= e_addr_next;
            t_addr_reg  <= t_addr_next;
            el_addr_reg <= element_index[EL_AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
        end
        else if (cfg_valid)
        begin
            active_reg <= cfg_data;
        end
    end

    // Clearing sweep counter
    assign clr_last = (clr_cnt_reg == CLR_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg <= clr_last ? '0 : clr_cnt_reg + CLR_W'(1);
        end
    end

    // Increments
    assign e_inc    = e_rdata + CNT_W'(1);
    assign t_inc    = t_rdata + CNT_W'(1);
    assign el_inc   = el_rdata + TOT_W'(1);
    assign glob_inc = glob_reg + TOT_W'(1);

    // Memory ports: sweep writes zero, update writes the increment
    assign e_we  = (cmd.clr_step && ({1'b0, clr_cnt_reg} < E_DEPTH_L)) || (cmd.upd && ok_reg);
    assign t_we  = (cmd.clr_step && ({1'b0, clr_cnt_reg} < T_DEPTH_L)) || (cmd.upd && ok_reg);
    assign el_we = (cmd.clr_step && ({1'b0, clr_cnt_reg} < EL_DEPTH_L)) || (cmd.upd && ok_reg);

    assign e_waddr  = cmd.clr_step ? clr_cnt_reg[E_AW-1:0] : e_addr_reg;
    assign t_waddr  = cmd.clr_step ? clr_cnt_reg[T_AW-1:0] : t_addr_reg;
    assign el_waddr = cmd.clr_step ? clr_cnt_reg[EL_AW-1:0] : el_addr_reg;

    assign e_wdata  = cmd.clr_step ? '0 : e_inc;
    assign t_wdata  = cmd.clr_step ? '0 : t_inc;
    assign el_wdata = cmd.clr_step ? '0 : el_inc;

    assign e_re  = cmd.rd && ok_reg;
    assign t_re  = cmd.rd && ok_reg;
    assign el_re = cmd.rd && ok_reg;

    pceth_ram #(.WIDTH(CNT_W), .DEPTH(E_DEPTH)) u_energy_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .re    (e_re),
        .raddr (e_addr_reg),
        .rdata (e_rdata)
    );

    pceth_ram #(.WIDTH(CNT_W), .DEPTH(T_DEPTH)) u_time_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .re    (t_re),
        .raddr (t_addr_reg),
        .rdata (t_rdata)
    );

    pceth_ram #(.WIDTH(TOT_W), .DEPTH(EL_DEPTH)) u_elem_ram (
        .clk   (clk),
        .we    (el_we),
        .waddr (el_waddr),
        .wdata (el_wdata),
        .re    (el_re),
        .raddr (el_addr_reg),
        .rdata (el_rdata)
    );

    // Global total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glob_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            glob_reg <= '0;
        end
        else if (cmd.upd && ok_reg)
        begin
            glob_reg <= glob_inc;
        end
    end

    // Output register
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.upd || cmd.reply)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd)
        begin
            out_accepted_reg <= ok_reg;
            out_energy_reg   <= ok_reg ? e_inc : '0;
            out_time_reg     <= ok_reg ? t_inc : '0;
            out_elem_reg     <= ok_reg ? el_inc : '0;
            out_event_reg    <= ok_reg ? glob_inc : glob_reg;
        end
        else if (cmd.reply)
        begin
            out_accepted_reg <= 1'b1;
            out_energy_reg   <= '0;
            out_time_reg     <= '0;
            out_elem_reg     <= '0;
            out_event_reg    <= '0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_accepted      = out_accepted_reg;
    assign out_energy_count  = out_energy_reg;
    assign out_time_count    = out_time_reg;
    assign out_element_total = out_elem_reg;
    assign out_event_total   = out_event_reg;

    assign st.item_func = func;
    assign st.clr_last  = clr_last;
    assign st.out_free  = out_free;

    a_total_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.upd && ok_reg) |=> glob_reg == $past(glob_reg) + TOT_W'(1))
        else $error("global total did not advance on a counted event");

    a_reject_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.upd && !ok_reg) |-> !(e_we || t_we || el_we))
        else $error("rejected event wrote a store");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.upd || cmd.reply) |-> out_free)
        else $error("result loaded over an untaken result");

endmodule

[rtl/core/per_channel_energy_time_histogrammer_top.sv]
// Per-element energy/time histogrammer. An event transaction (func = 0) that
// names an element below min(active_elements, 384), an energy bin below 4096
// and a time bin below 1024 bumps that element's energy bin, time bin and
// total plus the global total, and returns the new counts; otherwise nothing
// changes and the result has accepted = 0 with the current global total.
// A clear transaction (func = 1) zeroes all stores and returns accepted = 1.
// An event passes through accept, RAM read, and update with result load, set
// by the read-modify-write through the registered-read histogram RAMs, and no
// new transaction is accepted until its update is done; a stalled result holds
// the update until the result register frees up. After reset and after every
// clear transaction a clearing pass writes one entry per cycle across all
// stores, sized by the energy histogram RAM, during which no transaction is
// accepted. Configuration writes are taken in any cycle (ready is tied high).
module per_channel_energy_time_histogrammer_top
    import pceth_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pceth_cfg_if.sink   cfg,
    pceth_in_if.sink    item,
    pceth_out_if.source result
);

    pceth_cmd_t cmd;
    pceth_sts_t st;

    // config always writable
    assign cfg.ready  = 1'b1;
    assign item.ready = cmd.in_ready;

    pceth_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .st       (st),
        .cmd      (cmd)
    );

    pceth_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .st                (st),
        .cfg_valid         (cfg.valid),
        .cfg_data          (cfg.active_elements),
        .func              (item.func),
        .element_index     (item.element_index),
        .energy_bin        (item.energy_bin),
        .time_bin          (item.time_bin),
        .out_ready         (result.ready),
        .out_valid         (result.valid),
        .out_accepted      (result.accepted),
        .out_energy_count  (result.energy_count),
        .out_time_count    (result.time_count),
        .out_element_total (result.element_total),
        .out_event_total   (result.event_total)
    );

endmodule
